// ===== sv/cbpg_pkg.sv =====
// Package for the cubic Bezier point generator: field widths, fixed-point
// formats and the widths of the shared multiplier datapath.
// No dependencies.
package cbpg_pkg;

  // Field widths
  localparam int COORD_BITS   = 10;
  localparam int FRAC_BITS    = 8;
  localparam int MAX_SEGMENTS = 63;
  localparam int SEG_BITS     = 6;
  localparam int OUT_BITS     = COORD_BITS + FRAC_BITS;

  // Curve parameter t has T_FRAC fractional bits, weights have W_FRAC
  localparam int T_FRAC  = 16;
  localparam int W_FRAC  = 3 * T_FRAC;
  localparam int W_BITS  = W_FRAC + 1;

  // Shared multiplier operands: a takes u, t, partial products and weights,
  // b takes u, t, 3u, 3t or a control coordinate
  localparam int MA_BITS = W_BITS + 1;
  localparam int MB_BITS = (T_FRAC + 3 > COORD_BITS) ? T_FRAC + 3 : COORD_BITS;
  localparam int ACC_BITS = W_BITS + COORD_BITS + 1;

  // Rounding of the weighted sum down to FRAC_BITS fractional bits
  localparam int RND_SHIFT = W_FRAC - FRAC_BITS;

endpackage

// ===== sv/cubic_bezier_point_generator_core.sv =====
// Cubic Bezier tessellator core: control point latch, t generator,
// sequencer and one shared multiplier with accumulators.
// Depends on cbpg_pkg.
//
// One item carries four control points and a segment count n; the block
// returns n+1 curve points (n = 0 returns P0 alone), the last one flagged.
// For n > 0, a restoring divider first forms 65536/n bit by bit.
// Each point then runs a program on the shared multiplier (six products for
// the Bernstein weights, eight weight by coordinate products, a last step to
// retire the last product) and a load step that loads the output register
// and steps t; a stalled output stretches the load step. The block takes no
// new item while one is in work, but accepts the next one while the final
// point still waits in the output register.
module cubic_bezier_point_generator_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [cbpg_pkg::COORD_BITS-1:0] p0_x,
  input  logic signed [cbpg_pkg::COORD_BITS-1:0] p0_y,
  input  logic signed [cbpg_pkg::COORD_BITS-1:0] p1_x,
  input  logic signed [cbpg_pkg::COORD_BITS-1:0] p1_y,
  input  logic signed [cbpg_pkg::COORD_BITS-1:0] p2_x,
  input  logic signed [cbpg_pkg::COORD_BITS-1:0] p2_y,
  input  logic signed [cbpg_pkg::COORD_BITS-1:0] p3_x,
  input  logic signed [cbpg_pkg::COORD_BITS-1:0] p3_y,
  input  logic        [cbpg_pkg::SEG_BITS-1:0]   segments,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [cbpg_pkg::OUT_BITS-1:0]   curve_x,
  output logic signed [cbpg_pkg::OUT_BITS-1:0]   curve_y,
  output logic        [cbpg_pkg::SEG_BITS-1:0]   point_index,
  output logic                                last
);
  import cbpg_pkg::*;

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_CALC = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  // Write-back targets of the multiplier
  localparam logic [3:0] D_NONE     = 4'd0;
  localparam logic [3:0] D_UU       = 4'd1;
  localparam logic [3:0] D_TT       = 4'd2;
  localparam logic [3:0] D_W0       = 4'd3;
  localparam logic [3:0] D_W1       = 4'd4;
  localparam logic [3:0] D_W2       = 4'd5;
  localparam logic [3:0] D_W3       = 4'd6;
  localparam logic [3:0] D_ACCX_LD  = 4'd7;
  localparam logic [3:0] D_ACCX_ADD = 4'd8;
  localparam logic [3:0] D_ACCY_LD  = 4'd9;
  localparam logic [3:0] D_ACCY_ADD = 4'd10;

  localparam logic [3:0] LAST_STEP = 4'd14;
  localparam logic [T_FRAC:0] T_ONE = (T_FRAC + 1)'(1) << T_FRAC;
  localparam logic [4:0] DIV_TOP = 5'(T_FRAC);
  localparam logic [ACC_BITS-1:0] RND_HALF = ACC_BITS'(1) << (RND_SHIFT - 1);

  logic [1:0]               state;
  logic [3:0]               step;
  logic [4:0]               div_cnt;
  logic [SEG_BITS-1:0]      seg;
  logic [SEG_BITS-1:0]      idx;
  logic [T_FRAC:0]          q0;
  logic [SEG_BITS-1:0]      r0;
  logic [SEG_BITS-1:0]      rem;
  logic [T_FRAC:0]          t;
  logic [SEG_BITS-1:0]      r;
  logic signed [COORD_BITS-1:0] ctrl [8];

  logic [W_BITS-1:0]        uu;
  logic [W_BITS-1:0]        tt;
  logic [W_BITS-1:0]        w [4];
  logic signed [ACC_BITS-1:0] prod;
  logic [3:0]               dest;
  logic signed [ACC_BITS-1:0] acc_x;
  logic signed [ACC_BITS-1:0] acc_y;

  logic [T_FRAC:0]          u;
  logic [T_FRAC+1:0]        t3;
  logic [T_FRAC+1:0]        u3;
  logic signed [MA_BITS-1:0] op_a;
  logic signed [MB_BITS-1:0] op_b;
  logic [3:0]               op_dest;
  logic signed [MA_BITS+MB_BITS-1:0] mult_full;
  logic [SEG_BITS:0]        rem_shift;
  logic                     rem_ge;
  logic [SEG_BITS:0]        r_sum;
  logic                     r_wrap;
  logic signed [ACC_BITS-1:0] rnd_x;
  logic signed [ACC_BITS-1:0] rnd_y;
  logic signed [ACC_BITS-1:0] shr_x;
  logic signed [ACC_BITS-1:0] shr_y;
  logic                     out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Form 1-t and the tripled multipliers
  assign u  = T_ONE - t;
  assign t3 = {1'b0, t} + {t, 1'b0};
  assign u3 = {1'b0, u} + {u, 1'b0};

  // Restoring divider step for 65536 / n
  assign rem_shift = {rem, (div_cnt == DIV_TOP)};
  assign rem_ge    = (rem_shift >= {1'b0, seg});

  // Step the remainder of i*65536/n
  assign r_sum  = {1'b0, r} + {1'b0, r0};
  assign r_wrap = (r_sum >= {1'b0, seg});

  // Select multiplier operands for the current step
  always_comb begin
    op_a    = '0;
    op_b    = '0;
    op_dest = D_NONE;
    if (state == S_CALC) begin
      case (step)
        4'd0: begin
          op_a = MA_BITS'(u);  op_b = MB_BITS'(u);  op_dest = D_UU;
        end
        4'd1: begin
          op_a = MA_BITS'(t);  op_b = MB_BITS'(t);  op_dest = D_TT;
        end
        4'd2: begin
          op_a = MA_BITS'(uu); op_b = MB_BITS'(u);  op_dest = D_W0;
        end
        4'd3: begin
          op_a = MA_BITS'(uu); op_b = MB_BITS'(t3); op_dest = D_W1;
        end
        4'd4: begin
          op_a = MA_BITS'(tt); op_b = MB_BITS'(t);  op_dest = D_W3;
        end
        4'd5: begin
          op_a = MA_BITS'(tt); op_b = MB_BITS'(u3); op_dest = D_W2;
        end
        4'd6: begin
          op_a = MA_BITS'(w[0]); op_b = MB_BITS'(ctrl[0]); op_dest = D_ACCX_LD;
        end
        4'd7: begin
          op_a = MA_BITS'(w[1]); op_b = MB_BITS'(ctrl[2]); op_dest = D_ACCX_ADD;
        end
        4'd8: begin
          op_a = MA_BITS'(w[2]); op_b = MB_BITS'(ctrl[4]); op_dest = D_ACCX_ADD;
        end
        4'd9: begin
          op_a = MA_BITS'(w[3]); op_b = MB_BITS'(ctrl[6]); op_dest = D_ACCX_ADD;
        end
        4'd10: begin
          op_a = MA_BITS'(w[0]); op_b = MB_BITS'(ctrl[1]); op_dest = D_ACCY_LD;
        end
        4'd11: begin
          op_a = MA_BITS'(w[1]); op_b = MB_BITS'(ctrl[3]); op_dest = D_ACCY_ADD;
        end
        4'd12: begin
          op_a = MA_BITS'(w[2]); op_b = MB_BITS'(ctrl[5]); op_dest = D_ACCY_ADD;
        end
        4'd13: begin
          op_a = MA_BITS'(w[3]); op_b = MB_BITS'(ctrl[7]); op_dest = D_ACCY_ADD;
        end
        default: begin
          op_a = '0; op_b = '0; op_dest = D_NONE;
        end
      endcase
    end
  end

  assign mult_full = op_a * op_b;

  // Round half-up to the output format
  assign rnd_x = acc_x + RND_HALF;
  assign rnd_y = acc_y + RND_HALF;
  assign shr_x = rnd_x >>> RND_SHIFT;
  assign shr_y = rnd_y >>> RND_SHIFT;

  // Register the product and its target
  always_ff @(posedge clk) begin
    prod <= mult_full[ACC_BITS-1:0];
    if (rst) begin
      dest <= D_NONE;
    end else begin
      dest <= op_dest;
    end
  end

  // Write back the previous product
  always_ff @(posedge clk) begin
    case (dest)
      D_UU:       uu    <= prod[W_BITS-1:0];
      D_TT:       tt    <= prod[W_BITS-1:0];
      D_W0:       w[0]  <= prod[W_BITS-1:0];
      D_W1:       w[1]  <= prod[W_BITS-1:0];
      D_W2:       w[2]  <= prod[W_BITS-1:0];
      D_W3:       w[3]  <= prod[W_BITS-1:0];
      D_ACCX_LD:  acc_x <= prod;
      D_ACCX_ADD: acc_x <= acc_x + prod;
      D_ACCY_LD:  acc_y <= prod;
      D_ACCY_ADD: acc_y <= acc_y + prod;
      default: ;
    endcase
  end

  // Latch the control points of an accepted item
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      ctrl[0] <= p0_x;
      ctrl[1] <= p0_y;
      ctrl[2] <= p1_x;
      ctrl[3] <= p1_y;
      ctrl[4] <= p2_x;
      ctrl[5] <= p2_y;
      ctrl[6] <= p3_x;
      ctrl[7] <= p3_y;
    end
  end

  // Sequencer: divide, step t, run the multiplier program, emit
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      step    <= '0;
      div_cnt <= '0;
      seg     <= '0;
      idx     <= '0;
      q0      <= '0;
      r0      <= '0;
      rem     <= '0;
      t       <= '0;
      r       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (segments > SEG_BITS'(MAX_SEGMENTS)) begin
              seg <= SEG_BITS'(MAX_SEGMENTS);
            end else begin
              seg <= segments;
            end
            idx  <= '0;
            t    <= '0;
            r    <= '0;
            step <= '0;
            rem  <= '0;
            q0   <= '0;
            div_cnt <= DIV_TOP;
            if (segments == '0) begin
              state <= S_CALC;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          q0 <= {q0[T_FRAC-1:0], rem_ge};
          if (rem_ge) begin
            rem <= SEG_BITS'(rem_shift - {1'b0, seg});
          end else begin
            rem <= rem_shift[SEG_BITS-1:0];
          end
          if (div_cnt == '0) begin
            if (rem_ge) begin
              r0 <= SEG_BITS'(rem_shift - {1'b0, seg});
            end else begin
              r0 <= rem_shift[SEG_BITS-1:0];
            end
            state <= S_CALC;
          end else begin
            div_cnt <= div_cnt - 5'd1;
          end
        end
        S_CALC: begin
          if (step == LAST_STEP) begin
            step  <= '0;
            state <= S_EMIT;
          end else begin
            step <= step + 4'd1;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (idx == seg) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + SEG_BITS'(1);
              t     <= t + q0 + (T_FRAC + 1)'(r_wrap);
              if (r_wrap) begin
                r <= SEG_BITS'(r_sum - {1'b0, seg});
              end else begin
                r <= r_sum[SEG_BITS-1:0];
              end
              state <= S_CALC;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register: load a point when free, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      curve_x     <= shr_x[OUT_BITS-1:0];
      curve_y     <= shr_y[OUT_BITS-1:0];
      point_index <= idx;
      last        <= (idx == seg);
    end
  end

  // Multiplier write-backs come only from the point program
  a_dest_idle: assert property (@(posedge clk) disable iff (rst)
    (state != S_CALC) |-> (dest == D_NONE))
    else $error("multiplier write-back outside point program");

  // Remainder of the t generator stays below n
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CALC && seg != '0) |-> (r < seg))
    else $error("t remainder out of range");

  // Point counter never runs past n
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (idx <= seg))
    else $error("point counter beyond segment count");

  // Final point of a non-empty item sits exactly at t = 1
  a_t_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_CALC && seg != '0 && idx == seg) |-> (t == T_ONE))
    else $error("final point not at t = 1");

  // Loading the final point returns the block to idle
  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_free && idx == seg) |=> (state == S_IDLE && out_valid && last))
    else $error("item did not close after final point");

endmodule

// ===== verif/tb_cubic_bezier_point_generator_core.sv =====
// Self-checking testbench for cubic_bezier_point_generator_core: bursty control point
// items in, randomly stalled curve points out, each point checked against a local model.
// Depends on cbpg_pkg and the core.
`timescale 1ns / 100ps

module tb_cubic_bezier_point_generator_core;
  import cbpg_pkg::*;

  localparam longint T_ONE        = longint'(1) << T_FRAC;
  localparam int     IDLE_LIMIT   = 5000;
  localparam int     DRAIN_CYCLES = 1200;
  localparam int     RANDOM_ITEMS = 370;

  typedef struct packed {
    logic [3:0][COORD_BITS-1:0] cx;
    logic [3:0][COORD_BITS-1:0] cy;
    logic [SEG_BITS-1:0]        segs;
  } curve_item_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] x;
    logic [OUT_BITS-1:0] y;
    logic [SEG_BITS-1:0] idx;
    logic                last;
  } curve_point_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_HEAVY} stall_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic signed [COORD_BITS-1:0] p0_x = '0, p0_y = '0, p1_x = '0, p1_y = '0;
  logic signed [COORD_BITS-1:0] p2_x = '0, p2_y = '0, p3_x = '0, p3_y = '0;
  logic [SEG_BITS-1:0]          segments = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [OUT_BITS-1:0]   curve_x, curve_y;
  logic [SEG_BITS-1:0]          point_index;
  logic                         last;

  curve_item_t  pending_curves[$];
  curve_point_t expected_points[$];
  int           curves_queued   = 0;
  int           curves_accepted = 0;
  int           fail_count      = 0;
  int           idle_cycles     = 0;

  cubic_bezier_point_generator_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .p0_x(p0_x), .p0_y(p0_y), .p1_x(p1_x), .p1_y(p1_y),
    .p2_x(p2_x), .p2_y(p2_y), .p3_x(p3_x), .p3_y(p3_y),
    .segments(segments),
    .out_valid(out_valid), .out_stall(out_stall),
    .curve_x(curve_x), .curve_y(curve_y),
    .point_index(point_index), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Work out every curve point that one item should produce
  function automatic void predict_curve_points(input curve_item_t it);
    longint       n, i, t, u, sx, sy;
    longint       w [4];
    curve_point_t pt;
    n = longint'(it.segs);
    for (i = 0; i <= n; i++) begin
      t = (n == 0) ? 0 : (i * T_ONE) / n;
      u = T_ONE - t;
      w[0] = u * u * u;
      w[1] = 3 * u * u * t;
      w[2] = 3 * u * t * t;
      w[3] = t * t * t;
      sx = 0;
      sy = 0;
      for (int k = 0; k < 4; k++) begin
        sx += w[k] * longint'($signed(it.cx[k]));
        sy += w[k] * longint'($signed(it.cy[k]));
      end
      // round half-up to the output fraction
      sx = (sx + (longint'(1) << (RND_SHIFT - 1))) >>> RND_SHIFT;
      sy = (sy + (longint'(1) << (RND_SHIFT - 1))) >>> RND_SHIFT;
      pt.x    = sx[OUT_BITS-1:0];
      pt.y    = sy[OUT_BITS-1:0];
      pt.idx  = i[SEG_BITS-1:0];
      pt.last = (i == n);
      expected_points.insert(expected_points.size(), pt);
    end
  endfunction

  function automatic int pick_coord();
    case ($urandom_range(0, 9))
      0:       return -(1 << (COORD_BITS - 1));
      1:       return (1 << (COORD_BITS - 1)) - 1;
      2:       return 0;
      3:       return -1;
      default: return int'($urandom_range(0, (1 << COORD_BITS) - 1)) - (1 << (COORD_BITS - 1));
    endcase
  endfunction

  // Keep most curves short so the run stays brief; a few reach the maximum
  function automatic int pick_segments();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)       return 0;
    else if (r < 70) return int'($urandom_range(1, 15));
    else if (r < 90) return int'($urandom_range(16, 47));
    else             return int'($urandom_range(48, MAX_SEGMENTS));
  endfunction

  task automatic add_curve(input int x0, y0, x1, y1, x2, y2, x3, y3,
                           input int n);
    curve_item_t it;
    it.cx = {COORD_BITS'(x3), COORD_BITS'(x2), COORD_BITS'(x1), COORD_BITS'(x0)};
    it.cy = {COORD_BITS'(y3), COORD_BITS'(y2), COORD_BITS'(y1), COORD_BITS'(y0)};
    it.segs = SEG_BITS'(n);
    pending_curves.insert(pending_curves.size(), it);
    curves_queued++;
  endtask

  // Fill the stimulus, release reset, then wait for the last point to drain
  initial begin
    // zero segments: P0 alone
    add_curve(0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_curve(-512, 511, 100, -100, 200, 300, 511, -512, 0);
    add_curve(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
              pick_coord(), pick_coord(), pick_coord(), pick_coord(), 0);
    // coordinate extremes and values around zero
    add_curve(511, 511, 511, 511, 511, 511, 511, 511, 1);
    add_curve(-512, -512, -512, -512, -512, -512, -512, -512, 1);
    add_curve(-512, -512, -512, -512, -512, -512, -512, -512, MAX_SEGMENTS);
    add_curve(511, 511, 511, 511, 511, 511, 511, 511, MAX_SEGMENTS);
    add_curve(-512, 511, 511, -512, -512, 511, 511, -512, 2);
    add_curve(511, -512, -512, 511, 511, -512, -512, 511, 3);
    add_curve(-512, -512, 511, 511, 511, 511, -512, -512, MAX_SEGMENTS);
    add_curve(-1, 0, 0, -1, -1, 0, 0, -1, 5);
    add_curve(1, -1, -1, 1, 1, -1, -1, 1, 7);
    add_curve(0, 0, 511, -512, -512, 511, 0, 0, 62);
    add_curve(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
              pick_coord(), pick_coord(), pick_coord(), pick_coord(), 4);
    add_curve(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
              pick_coord(), pick_coord(), pick_coord(), pick_coord(), 31);
    repeat (RANDOM_ITEMS)
      add_curve(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_segments());

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (curves_accepted != curves_queued || expected_points.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Driver: present items in bursts with random gaps, hold while stalled
  curve_item_t shown_curve;
  int          burst_left = 1;
  int          gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_curve_points(shown_curve);
        curves_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_curves.size() != 0) begin
          shown_curve = pending_curves.pop_front();
          p0_x     <= shown_curve.cx[0];
          p0_y     <= shown_curve.cy[0];
          p1_x     <= shown_curve.cx[1];
          p1_y     <= shown_curve.cy[1];
          p2_x     <= shown_curve.cx[2];
          p2_y     <= shown_curve.cy[2];
          p3_x     <= shown_curve.cx[3];
          p3_y     <= shown_curve.cy[3];
          segments <= shown_curve.segs;
          in_valid <= 1'b1;
          // end of burst: pick the next burst length and the gap before it
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 6);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted point, stall in changing modes
  stall_mode_t  stall_mode = STALL_NONE;
  int           mode_left  = 0;
  curve_point_t want;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          $error("unexpected point: index %0d x %0d y %0d", point_index, curve_x, curve_y);
          fail_count++;
        end else begin
          want = expected_points.pop_front();
          if (curve_x !== want.x) begin
            $error("curve_x: expected %0d, actual %0d", $signed(want.x), curve_x);
            fail_count++;
          end
          if (curve_y !== want.y) begin
            $error("curve_y: expected %0d, actual %0d", $signed(want.y), curve_y);
            fail_count++;
          end
          if (point_index !== want.idx) begin
            $error("point_index: expected %0d, actual %0d", want.idx, point_index);
            fail_count++;
          end
          if (last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last);
            fail_count++;
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 2));
        mode_left  = $urandom_range(16, 200);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE:   out_stall <= 1'b0;
        STALL_RANDOM: out_stall <= 1'($urandom_range(0, 1));
        default:      out_stall <= ($urandom_range(0, 31) != 0);
      endcase
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

endmodule

// ===== sim.f =====
sv/cbpg_pkg.sv
sv/cubic_bezier_point_generator_core.sv
verif/tb_cubic_bezier_point_generator_core.sv
